/* src/csc_tbm_pkg.sv */
// ----------------------------------------------------------------------------
// csc_tbm_pkg
// Shared types, constants and fixed-point helpers for the sparse transpose
// times dense block multiply-accumulate.
// ----------------------------------------------------------------------------
package csc_tbm_pkg;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned ACC_W    = 64;
    localparam int unsigned ROW_W    = 12;
    localparam int unsigned COL_W    = 16;
    localparam int unsigned BR_W     = 3;
    localparam int unsigned PORT_LN  = 4;
    localparam int unsigned PADDR_W  = 3;
    localparam int unsigned PDATA_W  = 32;
    localparam int unsigned FRAC_W   = 16;

    localparam logic [BR_W-1:0] BLOCK_ROWS_RESET = 3'd4;
    localparam logic [BR_W-1:0] BLOCK_ROWS_MIN   = 3'd2;

    // register index, taken from paddr[2]
    localparam logic REG_BLOCK_ROWS = 1'b0;

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_NONZERO = 2'd1,
        CMD_EMPTY   = 2'd2,
        CMD_UNUSED  = 2'd3
    } t_cmd;

    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic signed [ACC_W-1:0]  t_acc;

    localparam t_acc ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam t_acc ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam t_data DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam t_data DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // 64-bit add that clamps on signed overflow
    function automatic t_acc sat_add64(input t_acc acc, input t_acc b);
        t_acc s;
        s = acc + b;
        if (!acc[ACC_W-1] && !b[ACC_W-1] && s[ACC_W-1]) begin
            return ACC_MAX;
        end else if (acc[ACC_W-1] && b[ACC_W-1] && !s[ACC_W-1]) begin
            return ACC_MIN;
        end
        return s;
    endfunction

    // q32.32 to q16.16: arithmetic shift (floor), then clamp to 32 bits
    function automatic t_data q16_sat(input t_acc acc);
        logic [ACC_W-FRAC_W-1:0] sh;
        sh = acc[ACC_W-1:FRAC_W];
        if ((&sh[ACC_W-FRAC_W-1:DATA_W-1]) || !(|sh[ACC_W-FRAC_W-1:DATA_W-1])) begin
            return t_data'(sh[DATA_W-1:0]);
        end else if (sh[ACC_W-FRAC_W-1]) begin
            return DATA_MIN;
        end
        return DATA_MAX;
    endfunction

endpackage

/* src/csc_transpose_times_block_mac.sv */
// ----------------------------------------------------------------------------
// csc_transpose_times_block_mac
// Column-wise sparse matrix transpose times dense block, four lane MAC.
// ----------------------------------------------------------------------------
// Takes one transaction per cycle unless a result waits at a stalled output;
// then the whole pipeline holds, and o_in_stall follows i_out_stall only in
// that case. Stages from input to result: dense-row store read, lane
// multiply, accumulate, and the output register with the q16.16 clamp. The
// store read port and the 32x32 multiplier per lane each take one pipeline
// stage. Loads and command 3 travel as bubbles and give no result. The dense
// store has no reset; rows must be loaded before a nonzero reads them. Change
// block_rows only while the pipeline is empty; the block does not enforce it.
module csc_transpose_times_block_mac #(
    parameter int unsigned MAX_DENSE_ROWS = 4096,
    parameter int unsigned MAX_COLUMNS    = 65536,
    parameter int unsigned LANES          = 4
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // apb configuration
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [csc_tbm_pkg::PADDR_W-1:0]       paddr,
    input  logic [csc_tbm_pkg::PDATA_W-1:0]       pwdata,
    output logic [csc_tbm_pkg::PDATA_W-1:0]       prdata,
    output logic                                  pready,
    // input channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [1:0]                            i_command,
    input  logic [csc_tbm_pkg::ROW_W-1:0]         i_row_index,
    input  logic signed [csc_tbm_pkg::DATA_W-1:0] i_a_value,
    input  logic                                  i_last_in_column,
    input  logic signed [csc_tbm_pkg::DATA_W-1:0] i_load_lane0,
    input  logic signed [csc_tbm_pkg::DATA_W-1:0] i_load_lane1,
    input  logic signed [csc_tbm_pkg::DATA_W-1:0] i_load_lane2,
    input  logic signed [csc_tbm_pkg::DATA_W-1:0] i_load_lane3,
    // result channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [csc_tbm_pkg::COL_W-1:0]         o_column_index,
    output logic signed [csc_tbm_pkg::DATA_W-1:0] o_sum_lane0,
    output logic signed [csc_tbm_pkg::DATA_W-1:0] o_sum_lane1,
    output logic signed [csc_tbm_pkg::DATA_W-1:0] o_sum_lane2,
    output logic signed [csc_tbm_pkg::DATA_W-1:0] o_sum_lane3
);
    import csc_tbm_pkg::*;

    localparam int unsigned ADDR_W = (MAX_DENSE_ROWS > 1) ? $clog2(MAX_DENSE_ROWS) : 1;
    localparam int unsigned COL_WRAP = (MAX_COLUMNS < 65536) ? MAX_COLUMNS : 65536;
    localparam int unsigned CNT_W = (COL_WRAP > 1) ? $clog2(COL_WRAP) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(COL_WRAP - 1);
    localparam int unsigned ROW_BITS = LANES * DATA_W;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    logic [BR_W-1:0] r_block_rows;
    logic            w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == REG_BLOCK_ROWS);
    assign prdata   = (paddr[2] == REG_BLOCK_ROWS) ? PDATA_W'(r_block_rows) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_rows <= BLOCK_ROWS_RESET;
        end else if (w_cfg_wr) begin
            r_block_rows <= pwdata[BR_W-1:0];
        end
    end

    logic [BR_W-1:0] w_lanes_used;
    assign w_lanes_used = (r_block_rows < BLOCK_ROWS_MIN) ? BLOCK_ROWS_MIN :
                          (r_block_rows > BR_W'(LANES)) ? BR_W'(LANES) : r_block_rows;

    // ------------------------------------------------------------------
    // input accept and dense store
    // ------------------------------------------------------------------
    logic        r_out_valid;
    logic        w_advance;
    logic        w_accept;
    t_cmd        w_cmd;
    logic [31:0] w_row_ext;
    logic [ADDR_W-1:0] w_addr;
    logic        w_in_range;
    t_data       w_load [PORT_LN];
    logic [ROW_BITS-1:0] w_wdata;
    logic        w_is_load;
    logic        w_is_item;

    assign w_advance  = !(r_out_valid && i_out_stall);
    assign o_in_stall = !w_advance;
    assign w_accept   = i_in_valid && w_advance;
    assign w_cmd      = t_cmd'(i_command);
    assign w_row_ext  = 32'(i_row_index);
    assign w_addr     = w_row_ext[ADDR_W-1:0];
    assign w_in_range = w_row_ext < MAX_DENSE_ROWS;

    assign w_load[0] = i_load_lane0;
    assign w_load[1] = i_load_lane1;
    assign w_load[2] = i_load_lane2;
    assign w_load[3] = i_load_lane3;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            w_wdata[l*DATA_W +: DATA_W] = w_load[l];
        end
    end

    always_comb begin
        w_is_load = 1'b0;
        w_is_item = 1'b0;
        unique case (w_cmd)
            CMD_LOAD:                 w_is_load = 1'b1;
            CMD_NONZERO, CMD_EMPTY:   w_is_item = 1'b1;
            CMD_UNUSED:               w_is_item = 1'b0;
            default:                  w_is_item = 1'b0;
        endcase
    end

    logic [ROW_BITS-1:0] r_store [MAX_DENSE_ROWS];
    logic [ROW_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (w_accept && w_is_load && w_in_range) begin
            r_store[w_addr] <= w_wdata;
        end
        if (w_accept) begin
            r_rd_data <= r_store[w_addr];
        end
    end

    // ------------------------------------------------------------------
    // stage 1: store data ready, stage 2: lane products
    // ------------------------------------------------------------------
    logic  r_s1_valid;
    logic  r_s1_nz;
    logic  r_s1_emit;
    logic  r_s1_in_range;
    t_data r_s1_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_advance) begin
            r_s1_valid <= w_accept && w_is_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_s1_nz       <= (w_cmd == CMD_NONZERO);
            r_s1_emit     <= (w_cmd == CMD_EMPTY) || i_last_in_column;
            r_s1_in_range <= w_in_range;
            r_s1_a        <= i_a_value;
        end
    end

    logic  r_s2_valid;
    logic  r_s2_nz;
    logic  r_s2_emit;
    t_acc  r_s2_prod [LANES];
    t_data w_x [LANES];

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            w_x[l] = r_s1_in_range ? t_data'(r_rd_data[l*DATA_W +: DATA_W]) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_advance) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_s2_nz   <= r_s1_nz;
            r_s2_emit <= r_s1_emit;
            for (int l = 0; l < LANES; l++) begin
                // signed 32x32, full 64-bit product
                r_s2_prod[l] <= r_s1_a * w_x[l];
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 3: accumulate, hand the column sums on at emission
    // ------------------------------------------------------------------
    t_acc r_acc [LANES];
    t_acc w_sum [LANES];
    t_acc r_s3_acc [LANES];
    logic r_s3_valid;
    logic [CNT_W-1:0] r_col_cnt;
    logic [CNT_W-1:0] r_s3_col;
    logic w_emit;

    assign w_emit = r_s2_valid && (!r_s2_nz || r_s2_emit);

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            if (r_s2_nz && (BR_W'(l) < w_lanes_used)) begin
                w_sum[l] = sat_add64(r_acc[l], r_s2_prod[l]);
            end else begin
                w_sum[l] = r_acc[l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < LANES; l++) begin
                r_acc[l] <= '0;
            end
            r_col_cnt  <= '0;
            r_s3_valid <= 1'b0;
        end else if (w_advance) begin
            r_s3_valid <= w_emit;
            if (w_emit) begin
                for (int l = 0; l < LANES; l++) begin
                    r_acc[l] <= '0;
                end
                r_col_cnt <= (r_col_cnt == CNT_LAST) ? '0 : r_col_cnt + 1'b1;
            end else if (r_s2_valid) begin
                for (int l = 0; l < LANES; l++) begin
                    r_acc[l] <= w_sum[l];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_s3_col <= r_col_cnt;
            for (int l = 0; l < LANES; l++) begin
                r_s3_acc[l] <= w_sum[l];
            end
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    t_data            r_out_sum [LANES];
    logic [COL_W-1:0] r_out_col;
    t_data            w_out [PORT_LN];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_col <= COL_W'(r_s3_col);
            for (int l = 0; l < LANES; l++) begin
                r_out_sum[l] <= (BR_W'(l) < w_lanes_used) ? q16_sat(r_s3_acc[l]) : '0;
            end
        end
    end

    for (genvar g = 0; g < PORT_LN; g++) begin : g_out_lane
        if (g < LANES) begin : g_used
            assign w_out[g] = r_out_sum[g];
        end else begin : g_unused
            assign w_out[g] = '0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_column_index = r_out_col;
    assign o_sum_lane0    = w_out[0];
    assign o_sum_lane1    = w_out[1];
    assign o_sum_lane2    = w_out[2];
    assign o_sum_lane3    = w_out[3];

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_acc_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_emit) |=> (r_acc[0] == '0))
        else $error("accumulator not cleared after emission");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_advance |=> ($stable(r_s1_valid) && $stable(r_s2_valid) && $stable(r_s3_valid)))
        else $error("pipeline moved while output stalled");

    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_is_item) |=> !r_s1_valid)
        else $error("load or unused command entered result pipeline");

    a_count_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_emit) |=> (r_s3_col == $past(r_col_cnt)))
        else $error("column index does not match counter");

endmodule

/* test/csc_transpose_times_block_mac_tb.sv */
// ----------------------------------------------------------------------------
// csc_transpose_times_block_mac_tb
// Self-checking bench for the sparse transpose times dense block MAC. A
// directed table covers reset, saturation, floor rounding, ignored fields and
// read-after-load. Random column streams then run under every block_rows
// setting, with random stalls on both sides and a long output hold-off.
// Each result is checked against a behavioral predictor.
// ----------------------------------------------------------------------------
module csc_transpose_times_block_mac_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import csc_tbm_pkg::*;

    localparam int   STORE_ROWS   = 4096;
    localparam int   PHASE_ITEMS  = 90;
    localparam int   PLAN_LEN     = 8;
    localparam int   HOLD_PHASE   = 2;
    localparam int   HOLD_CYCLES  = 400;
    localparam int   DRAIN_CYCLES = 8;
    localparam int   IDLE_LIMIT   = 4000;
    localparam t_data ONE         = 32'sh0001_0000;
    localparam t_data NEG_ONE     = 32'shFFFF_0000;
    localparam logic [PADDR_W-1:0] BLOCK_ROWS_ADDR = PADDR_W'(4 * int'(REG_BLOCK_ROWS));
    localparam logic [BR_W-1:0] BR_PLAN [PLAN_LEN] =
        '{3'd2, 3'd3, 3'd0, 3'd1, 3'd7, 3'd5, 3'd6, 3'd4};

    typedef struct packed {
        t_cmd             cmd;
        logic [ROW_W-1:0] row;
        t_data            a;
        logic             last;
        t_data [3:0]      lane;
    } t_mac_txn;

    typedef struct packed {
        logic [COL_W-1:0] column;
        t_data [3:0]      sum;
    } t_col_sums;

    typedef struct packed {
        t_mac_txn  txn;
        logic      typed;
        t_col_sums want;
    } t_dir_row;

    logic               i_clk            = 1'b0;
    logic               i_rst_n          = 1'b0;
    logic               psel             = 1'b0;
    logic               penable          = 1'b0;
    logic               pwrite           = 1'b0;
    logic [PADDR_W-1:0] paddr            = '0;
    logic [PDATA_W-1:0] pwdata           = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               i_in_valid       = 1'b0;
    logic               o_in_stall;
    logic [1:0]         i_command        = '0;
    logic [ROW_W-1:0]   i_row_index      = '0;
    t_data              i_a_value        = '0;
    logic               i_last_in_column = 1'b0;
    t_data              i_load_lane0     = '0;
    t_data              i_load_lane1     = '0;
    t_data              i_load_lane2     = '0;
    t_data              i_load_lane3     = '0;
    logic               o_out_valid;
    logic               i_out_stall      = 1'b0;
    logic [COL_W-1:0]   o_column_index;
    t_data              o_sum_lane0;
    t_data              o_sum_lane1;
    t_data              o_sum_lane2;
    t_data              o_sum_lane3;

    // predictor state
    t_data            dense_rows [STORE_ROWS][4];
    bit               row_loaded [STORE_ROWS];
    int               loaded_list [$];
    int               last_loaded;
    t_acc             lane_acc [4];
    logic [COL_W-1:0] col_count;
    logic [BR_W-1:0]  block_rows_cfg;

    t_col_sums pending_sums [$];
    t_dir_row  dir_rows [$];
    int        mismatches   = 0;
    int        items_in     = 0;
    int        results_seen = 0;
    bit        sender_gaps  = 1'b1;
    bit        quiet_tail   = 1'b0;
    bit        hold_req     = 1'b0;

    csc_transpose_times_block_mac u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_command        (i_command),
        .i_row_index      (i_row_index),
        .i_a_value        (i_a_value),
        .i_last_in_column (i_last_in_column),
        .i_load_lane0     (i_load_lane0),
        .i_load_lane1     (i_load_lane1),
        .i_load_lane2     (i_load_lane2),
        .i_load_lane3     (i_load_lane3),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_column_index   (o_column_index),
        .o_sum_lane0      (o_sum_lane0),
        .o_sum_lane1      (o_sum_lane1),
        .o_sum_lane2      (o_sum_lane2),
        .o_sum_lane3      (o_sum_lane3)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic log_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    // 65-bit sum, clamped back into the signed 64-bit range
    function automatic t_acc acc_add_clamped(input t_acc x, input t_acc y);
        logic [ACC_W:0] wide;
        wide = {x[ACC_W-1], x} + {y[ACC_W-1], y};
        if (wide[ACC_W] != wide[ACC_W-1]) begin
            return wide[ACC_W] ? ACC_MIN : ACC_MAX;
        end
        return t_acc'(wide[ACC_W-1:0]);
    endfunction

    function automatic t_data acc_to_q16(input t_acc x);
        t_acc sh;
        sh = x >>> FRAC_W;
        if (sh > t_acc'(DATA_MAX)) begin
            return DATA_MAX;
        end
        if (sh < t_acc'(DATA_MIN)) begin
            return DATA_MIN;
        end
        return t_data'(sh[DATA_W-1:0]);
    endfunction

    // advances the predicted block by one transaction, returns 1 on a column result
    function automatic bit step_block_mac(input t_mac_txn t, output t_col_sums r);
        int   lanes;
        int   l;
        t_acc prod;
        r = '0;
        if (block_rows_cfg < BLOCK_ROWS_MIN) begin
            lanes = int'(BLOCK_ROWS_MIN);
        end else if (block_rows_cfg > BR_W'(PORT_LN)) begin
            lanes = PORT_LN;
        end else begin
            lanes = int'(block_rows_cfg);
        end
        case (t.cmd)
            CMD_LOAD: begin
                for (l = 0; l < 4; l++) begin
                    dense_rows[t.row][l] = t.lane[l];
                end
                if (!row_loaded[t.row]) begin
                    row_loaded[t.row] = 1'b1;
                    loaded_list.push_back(int'(t.row));
                end
                last_loaded = int'(t.row);
                return 1'b0;
            end
            CMD_NONZERO: begin
                for (l = 0; l < lanes; l++) begin
                    prod = t_acc'($signed(t.a)) * t_acc'($signed(dense_rows[t.row][l]));
                    lane_acc[l] = acc_add_clamped(lane_acc[l], prod);
                end
                if (!t.last) begin
                    return 1'b0;
                end
            end
            CMD_EMPTY: begin
            end
            default: begin
                return 1'b0;
            end
        endcase
        r.column = col_count;
        for (l = 0; l < 4; l++) begin
            r.sum[l] = (l < lanes) ? acc_to_q16(lane_acc[l]) : '0;
            lane_acc[l] = '0;
        end
        col_count++;
        return 1'b1;
    endfunction

    function automatic t_mac_txn mk_txn(input t_cmd cmd, input logic [ROW_W-1:0] row,
                                        input t_data a, input logic last,
                                        input t_data l0, l1, l2, l3);
        t_mac_txn t;
        t.cmd     = cmd;
        t.row     = row;
        t.a       = a;
        t.last    = last;
        t.lane[0] = l0;
        t.lane[1] = l1;
        t.lane[2] = l2;
        t.lane[3] = l3;
        return t;
    endfunction

    function automatic t_col_sums mk_sums(input logic [COL_W-1:0] column,
                                          input t_data s0, s1, s2, s3);
        t_col_sums r;
        r.column = column;
        r.sum[0] = s0;
        r.sum[1] = s1;
        r.sum[2] = s2;
        r.sum[3] = s3;
        return r;
    endfunction

    task automatic add_row(input t_mac_txn t, input logic typed, input t_col_sums want);
        t_dir_row d;
        d.txn   = t;
        d.typed = typed;
        d.want  = want;
        dir_rows.push_back(d);
    endtask

    function automatic t_data rand_q16();
        case ($urandom_range(0, 7))
            0: return DATA_MAX;
            1: return DATA_MIN;
            2, 3: return t_data'(int'($urandom_range(0, 8 << FRAC_W)) - (4 << FRAC_W));
            default: return t_data'($urandom);
        endcase
    endfunction

    function automatic t_mac_txn rand_other(input t_cmd cmd);
        t_mac_txn t;
        int       l;
        t.cmd  = cmd;
        t.row  = ROW_W'($urandom);
        t.a    = t_data'($urandom);
        t.last = 1'($urandom);
        for (l = 0; l < 4; l++) begin
            t.lane[l] = t_data'($urandom);
        end
        return t;
    endfunction

    function automatic t_mac_txn rand_load();
        t_mac_txn t;
        int       l;
        t = rand_other(CMD_LOAD);
        // mostly a small pool of rows so nonzeros often hit a fresh load
        if ($urandom_range(0, 2) != 0) begin
            t.row = ROW_W'($urandom_range(0, 15));
        end
        for (l = 0; l < 4; l++) begin
            t.lane[l] = rand_q16();
        end
        return t;
    endfunction

    // only rows that were loaded are read, the store is undefined elsewhere
    function automatic t_mac_txn rand_nonzero(input logic last);
        t_mac_txn t;
        t      = rand_other(CMD_NONZERO);
        t.a    = rand_q16();
        t.last = last;
        if ($urandom_range(0, 3) == 0) begin
            t.row = ROW_W'(last_loaded);
        end else begin
            t.row = ROW_W'(loaded_list[$urandom_range(0, loaded_list.size() - 1)]);
        end
        return t;
    endfunction

    task automatic send_txn(input t_mac_txn t, input logic typed, input t_col_sums want);
        t_col_sums res;
        if (sender_gaps && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_command        <= t.cmd;
        i_row_index      <= t.row;
        i_a_value        <= t.a;
        i_last_in_column <= t.last;
        i_load_lane0     <= t.lane[0];
        i_load_lane1     <= t.lane[1];
        i_load_lane2     <= t.lane[2];
        i_load_lane3     <= t.lane[3];
        do @(posedge i_clk); while (o_in_stall);
        if (t.cmd != CMD_UNUSED) begin
            items_in++;
        end
        if (step_block_mac(t, res)) begin
            pending_sums.push_back(typed ? want : res);
        end
    endtask

    // leaves psel high so that transfers can follow back to back
    task automatic apb_xfer(input logic wr, input logic [PADDR_W-1:0] addr,
                            input logic [PDATA_W-1:0] wdata,
                            output logic [PDATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
    endtask

    task automatic set_block_rows(input logic [BR_W-1:0] v);
        logic [PDATA_W-1:0] rd;
        while (pending_sums.size() != 0) @(posedge i_clk);
        // loads give no result and may still be in flight
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        apb_xfer(1'b1, BLOCK_ROWS_ADDR, PDATA_W'(v), rd);
        block_rows_cfg = v;
        apb_xfer(1'b0, BLOCK_ROWS_ADDR, '0, rd);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd[BR_W-1:0] !== v) begin
            log_mismatch($sformatf("block_rows readback: expected %0d, got %0d",
                                   v, rd[BR_W-1:0]));
        end
    endtask

    task automatic random_phase(input int n_items);
        int done;
        int k;
        int i;
        int pick;
        done = 0;
        while (done < n_items) begin
            pick = $urandom_range(0, 19);
            if (pick < 3) begin
                send_txn(rand_load(), 1'b0, '0);
                done++;
            end else if (pick < 15) begin
                // well-formed column, now and then long enough to saturate
                k = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
                for (i = 0; i < k; i++) begin
                    if ($urandom_range(0, 7) == 0) begin
                        send_txn(rand_load(), 1'b0, '0);
                        done++;
                    end
                    send_txn(rand_nonzero(i == k - 1), 1'b0, '0);
                    done++;
                end
            end else if (pick < 17) begin
                send_txn(rand_other(CMD_EMPTY), 1'b0, '0);
                done++;
            end else if (pick < 18) begin
                send_txn(rand_other(CMD_UNUSED), 1'b0, '0);
            end else begin
                // column left open, closed by an empty item or by the next column
                k = $urandom_range(1, 4);
                for (i = 0; i < k; i++) begin
                    send_txn(rand_nonzero(1'b0), 1'b0, '0);
                    done++;
                end
                if ($urandom_range(0, 1) == 0) begin
                    send_txn(rand_other(CMD_EMPTY), 1'b0, '0);
                    done++;
                end
            end
        end
    endtask

    // result side
    always @(posedge i_clk) begin : result_check
        t_col_sums want;
        t_data     got_sum [4];
        int        l;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            got_sum[0] = o_sum_lane0;
            got_sum[1] = o_sum_lane1;
            got_sum[2] = o_sum_lane2;
            got_sum[3] = o_sum_lane3;
            if (pending_sums.size() == 0) begin
                log_mismatch($sformatf("unexpected result for column %0d", o_column_index));
            end else begin
                want = pending_sums.pop_front();
                if (o_column_index !== want.column) begin
                    log_mismatch($sformatf("column index: expected %0d, got %0d",
                                           want.column, o_column_index));
                end
                for (l = 0; l < 4; l++) begin
                    if (got_sum[l] !== want.sum[l]) begin
                        log_mismatch($sformatf("column %0d lane %0d: expected %h, got %h",
                                               want.column, l, want.sum[l], got_sum[l]));
                    end
                end
            end
        end
    end

    // output back-pressure: random bursts, calm stretches, one long hold-off
    initial begin : out_pacing
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
                i_out_stall <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 15) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else if ($urandom_range(0, 63) == 0) begin
                repeat ($urandom_range(40, 160)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        int idle_cycles;
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
                $display("csc_transpose_times_block_mac regression: fail");
                $finish;
            end
        end
    end

    initial begin : stimulus
        logic [PDATA_W-1:0] rd;
        int                 p;
        int                 n;
        col_count      = '0;
        block_rows_cfg = BLOCK_ROWS_RESET;
        last_loaded    = 0;
        for (n = 0; n < 4; n++) begin
            lane_acc[n] = '0;
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        apb_xfer(1'b0, BLOCK_ROWS_ADDR, '0, rd);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd[BR_W-1:0] !== BLOCK_ROWS_RESET) begin
            log_mismatch($sformatf("block_rows after reset: got %0d", rd[BR_W-1:0]));
        end

        // empty column straight out of reset, fields ignored
        add_row(mk_txn(CMD_EMPTY, 12'hABC, 32'shDEAD_BEEF, 1'b1,
                       32'sh1234_5678, DATA_MAX, DATA_MIN, 32'sh0F0F_0F0F),
                1'b1, mk_sums(16'd0, '0, '0, '0, '0));
        add_row(mk_txn(CMD_UNUSED, 12'h000, ONE, 1'b1, ONE, ONE, ONE, ONE), 1'b0, '0);
        add_row(mk_txn(CMD_LOAD, 12'h000, DATA_MIN, 1'b1, DATA_MAX, DATA_MIN, ONE, NEG_ONE),
                1'b0, '0);
        add_row(mk_txn(CMD_LOAD, 12'hFFF, '0, 1'b0, ONE, ONE, ONE, ONE), 1'b0, '0);
        add_row(mk_txn(CMD_NONZERO, 12'h000, ONE, 1'b1, DATA_MIN, '0, '0, DATA_MAX),
                1'b1, mk_sums(16'd1, DATA_MAX, DATA_MIN, ONE, NEG_ONE));
        // three full-scale products overflow the 64-bit accumulators of lanes 0 and 1
        add_row(mk_txn(CMD_NONZERO, 12'h000, DATA_MIN, 1'b0, ONE, ONE, ONE, ONE), 1'b0, '0);
        add_row(mk_txn(CMD_NONZERO, 12'h000, DATA_MIN, 1'b0, '0, '0, '0, '0), 1'b0, '0);
        add_row(mk_txn(CMD_NONZERO, 12'h000, DATA_MIN, 1'b1, '0, '0, '0, '0),
                1'b1, mk_sums(16'd2, DATA_MIN, DATA_MAX, DATA_MIN, DATA_MAX));
        add_row(mk_txn(CMD_NONZERO, 12'hFFF, ONE, 1'b0, '0, '0, '0, '0), 1'b0, '0);
        add_row(mk_txn(CMD_UNUSED, 12'hFFF, ONE, 1'b1, '0, '0, '0, '0), 1'b0, '0);
        // empty item flushes the open column
        add_row(mk_txn(CMD_EMPTY, 12'h555, DATA_MAX, 1'b0, '0, '0, '0, '0),
                1'b1, mk_sums(16'd3, ONE, ONE, ONE, ONE));
        add_row(mk_txn(CMD_EMPTY, 12'h000, '0, 1'b1, '0, '0, '0, '0),
                1'b1, mk_sums(16'd4, '0, '0, '0, '0));
        // floor rounding on small negative products
        add_row(mk_txn(CMD_LOAD, 12'h001, '0, 1'b0, -32'sd1, 32'sd1, DATA_MAX, 32'sh0000_8000),
                1'b0, '0);
        add_row(mk_txn(CMD_NONZERO, 12'h001, 32'sd1, 1'b1, '0, '0, '0, '0), 1'b0, '0);
        add_row(mk_txn(CMD_NONZERO, 12'h001, -32'sd1, 1'b0, '0, '0, '0, '0), 1'b0, '0);
        add_row(mk_txn(CMD_NONZERO, 12'h000, DATA_MAX, 1'b1, '0, '0, '0, '0), 1'b0, '0);
        // nonzero right behind a load of its row
        add_row(mk_txn(CMD_LOAD, 12'h000, '0, 1'b0,
                       ONE, NEG_ONE, 32'sh0003_8000, 32'shFFFC_8000), 1'b0, '0);
        add_row(mk_txn(CMD_NONZERO, 12'h000, 32'sh0002_0000, 1'b1, '0, '0, '0, '0), 1'b0, '0);
        add_row(mk_txn(CMD_LOAD, 12'h800, '0, 1'b0, 32'sh5555_5555, 32'shAAAA_AAAA,
                       32'sh7FFF_0001, 32'sh8000_FFFF), 1'b0, '0);
        add_row(mk_txn(CMD_NONZERO, 12'h800, NEG_ONE, 1'b1, '0, '0, '0, '0), 1'b0, '0);

        foreach (dir_rows[i]) begin
            send_txn(dir_rows[i].txn, dir_rows[i].typed, dir_rows[i].want);
        end
        i_in_valid <= 1'b0;

        for (p = 0; p < PLAN_LEN; p++) begin
            if (p == PLAN_LEN - 1) begin
                sender_gaps = 1'b0;
                quiet_tail  = 1'b1;
            end
            set_block_rows(BR_PLAN[p]);
            if (p == HOLD_PHASE) begin
                hold_req = 1'b1;
            end
            random_phase(PHASE_ITEMS);
            i_in_valid <= 1'b0;
        end

        while (pending_sums.size() != 0) @(posedge i_clk);
        repeat (2 * DRAIN_CYCLES) @(posedge i_clk);
        mismatches += pending_sums.size();

        $display("covered: %0d transactions in, %0d column results checked", items_in,
                 results_seen);
        $display("covered: block_rows 0 to 7, saturation, floor rounding, long hold-off");
        if (mismatches == 0) begin
            $display("csc_transpose_times_block_mac regression: pass");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("csc_transpose_times_block_mac regression: fail");
        end
        $finish;
    end

endmodule

/* csc_transpose_times_block_mac.f */
src/csc_tbm_pkg.sv
src/csc_transpose_times_block_mac.sv
test/csc_transpose_times_block_mac_tb.sv
